FILE: rtl/limit_order_book_levels_assert.svh
// Assertion helpers for the order book level block.
// Each macro needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef LIMIT_ORDER_BOOK_LEVELS_ASSERT_SVH
`define LIMIT_ORDER_BOOK_LEVELS_ASSERT_SVH

// Same-cycle implication.
`define LOBL_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("order book level check failed");

// Next-cycle implication.
`define LOBL_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("order book level check failed");

`endif

FILE: rtl/lobl_pkg.sv
// ----------------------------------------------------------------------------
// lobl_pkg
// Shared types and codes for the order book price level block.
// ----------------------------------------------------------------------------
`default_nettype none

package lobl_pkg;

	// Incoming request
	typedef struct packed {
		logic        req_type;
		logic [9:0]  order_id;
		logic [19:0] order_qty;
		logic [7:0]  price_tick;
		logic        sell_side;
	} req_t;

	// Outgoing result
	typedef struct packed {
		logic [1:0]  status;
		logic        bid_valid;
		logic [7:0]  best_bid;
		logic        ask_valid;
		logic [7:0]  best_ask;
		logic [31:0] level_total;
	} rsp_t;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_DUP     = 2'd2;
	localparam logic [1:0] ST_OVF     = 2'd3;

	// Request kinds
	localparam logic REQ_ADD    = 1'b0;
	localparam logic REQ_CANCEL = 1'b1;

	// Occupancy bits held by one cell per side
	localparam int WORD_BITS = 8;

	// Largest order count a level may hold
	localparam logic [10:0] COUNT_MAX = 11'h7FF;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SLOT,
		S_LEVEL,
		S_SCAN,
		S_DONE
	} state_t;

	// Control broadcast to every cell
	typedef struct packed {
		logic       upd;
		logic       upd_set;
		logic       side;
		logic [2:0] bit_idx;
		logic       start;
		logic       scan_side;
	} cell_ctl_t;

	// Report from one cell
	typedef struct packed {
		logic       occ;
		logic       tok_out;
		logic       hit;
		logic [2:0] hit_pos;
	} cell_res_t;

endpackage

`default_nettype wire

FILE: rtl/lobl_cell.sv
// ----------------------------------------------------------------------------
// lobl_cell
// One word of level occupancy for both sides, with a scan token that walks
// the chain one cell per cycle until it meets an occupied word.
// ----------------------------------------------------------------------------
`default_nettype none

module lobl_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lobl_pkg::cell_ctl_t  ctl,
	input  logic                 sel,
	input  logic                 tok_in,
	output lobl_pkg::cell_res_t  res
);
	import lobl_pkg::*;

	logic [WORD_BITS-1:0] occ_bid_q;
	logic [WORD_BITS-1:0] occ_ask_q;
	logic                 tok_q;
	logic [WORD_BITS-1:0] word;
	logic [WORD_BITS-1:0] upd_word;
	logic [2:0]           pos;

	// Hold occupancy and advance the scan token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_bid_q <= '0;
			occ_ask_q <= '0;
			tok_q     <= 1'b0;
		end else begin
			if (ctl.upd && sel) begin
				if (ctl.side) begin
					occ_ask_q[ctl.bit_idx] <= ctl.upd_set;
				end else begin
					occ_bid_q[ctl.bit_idx] <= ctl.upd_set;
				end
			end
			tok_q <= (ctl.start && sel) || tok_in;
		end
	end

	assign word     = ctl.scan_side ? occ_ask_q : occ_bid_q;
	assign upd_word = ctl.side ? occ_ask_q : occ_bid_q;

	// Pick lowest set bit for asks, highest for bids
	always_comb begin
		pos = '0;
		if (ctl.scan_side) begin
			for (int i = WORD_BITS - 1; i >= 0; i--) begin
				if (word[i]) pos = 3'(i);
			end
		end else begin
			for (int i = 0; i < WORD_BITS; i++) begin
				if (word[i]) pos = 3'(i);
			end
		end
	end

	assign res.occ     = sel && upd_word[ctl.bit_idx];
	assign res.tok_out = tok_q && (word == '0);
	assign res.hit     = tok_q && (word != '0);
	assign res.hit_pos = pos;

endmodule

`default_nettype wire

FILE: rtl/limit_order_book_levels.sv
// ----------------------------------------------------------------------------
// limit_order_book_levels
// Add and cancel requests update an order table and per-side price level
// tables; the result reports status, best bid, best ask and level quantity.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req/req_valid and are taken when req_stall is low.
//   Each request gives exactly one result on rsp/rsp_valid, held until an
//   edge where rsp_stall is low. The result register frees the request side,
//   so a new request is taken while an earlier result still waits.
//   Steps after acceptance: the slot read happens at acceptance, then level
//   read, update and result load into the result register.
//   A cancel that empties the best level adds a token walk along the
//   occupancy cell chain, one cell of eight ticks per cycle. One request at
//   a time.
//   After reset the order table live flags are swept, one slot per cycle;
//   req_stall stays high meanwhile. Level occupancy and the best pointers
//   clear at once.
//   A stalled result holds the block in its final step until the result
//   register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module limit_order_book_levels #(
	parameter int ORDER_SLOTS  = 1024,
	parameter int PRICE_LEVELS = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  lobl_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output lobl_pkg::rsp_t   rsp
);
	import lobl_pkg::*;

	`include "limit_order_book_levels_assert.svh"

	localparam int SW    = $clog2(ORDER_SLOTS);
	localparam int PW    = $clog2(PRICE_LEVELS);
	localparam int NCELL = (PRICE_LEVELS + WORD_BITS - 1) / WORD_BITS;
	localparam int CW    = (NCELL > 1) ? $clog2(NCELL) : 1;
	localparam int LAW   = PW + 1;

	typedef struct packed {
		logic          live;
		logic          side;
		logic [PW-1:0] price;
		logic [19:0]   qty;
	} slot_t;

	typedef struct packed {
		logic [31:0] qty;
		logic [10:0] cnt;
	} level_t;

	state_t         state_q, state_d;
	logic [SW-1:0]  clr_q;
	req_t           req_q;
	logic [PW-1:0]  tick_q;
	logic [SW-1:0]  slot_idx_q;
	logic           id_ok_q;
	slot_t          slot_rd_q;
	level_t         lvl_rd_q;
	logic           lvl_side_q;
	logic [PW-1:0]  lvl_q;
	logic [1:0]     status_q;
	logic [31:0]    total_q;
	logic           bid_ok_q, ask_ok_q;
	logic [PW-1:0]  bid_top_q, ask_top_q;
	logic           scan_side_q;
	logic           rsp_valid_q;
	rsp_t           rsp_q;

	slot_t          slot_mem [ORDER_SLOTS];
	level_t         lvl_mem [2**LAW];

	logic           accept;
	logic [SW-1:0]  slot_idx;
	logic [PW-1:0]  tick_sat;
	logic           slot_we;
	logic [SW-1:0]  slot_wa;
	slot_t          slot_wd;
	logic           lvl_we;
	level_t         lvl_wd;
	logic [LAW-1:0] lvl_ra;
	logic [LAW-1:0] lvl_wa;
	logic           rsp_load;

	logic           occ_cur;
	logic [31:0]    cur_qty;
	logic [10:0]    cur_cnt;
	logic [32:0]    sum;
	logic [31:0]    diff;
	logic [10:0]    cnt_dec;
	logic [1:0]     status_d;
	logic [31:0]    total_d;
	logic           add_ok, cancel_ok, need_scan;
	logic           set_ask, set_bid;

	cell_ctl_t        ctl;
	cell_res_t        res [NCELL];
	logic [NCELL-1:0] sel_v, tok_in_v, hit_v, occ_v;
	logic [PW-1:0]    widx;
	logic [CW-1:0]    hit_word;
	logic [2:0]       hit_pos;
	logic             hit_any, end_tok;
	logic [PW-1:0]    top_new;

	// Request side handshake and field shaping
	assign accept   = req_valid && !req_stall;
	assign slot_idx = SW'(req.order_id);
	assign tick_sat = (int'(req.price_tick) >= PRICE_LEVELS) ?
		PW'(PRICE_LEVELS - 1) : PW'(req.price_tick);
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == SW'(ORDER_SLOTS - 1)) state_d = S_IDLE;
			S_IDLE:  if (accept) state_d = S_SLOT;
			S_SLOT:  state_d = S_LEVEL;
			S_LEVEL: state_d = need_scan ? S_SCAN : S_DONE;
			S_SCAN:  if (hit_any || end_tok) state_d = S_DONE;
			S_DONE:  if (rsp_load) state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	// Level arithmetic on the current entry; an unoccupied level reads as empty
	assign occ_cur = |occ_v;
	assign cur_qty = occ_cur ? lvl_rd_q.qty : 32'd0;
	assign cur_cnt = occ_cur ? lvl_rd_q.cnt : 11'd0;
	assign sum     = {1'b0, cur_qty} + {13'd0, req_q.order_qty};
	assign diff    = cur_qty - {12'd0, slot_rd_q.qty};
	assign cnt_dec = (cur_cnt != 11'd0) ? (cur_cnt - 11'd1) : 11'd0;

	// Decide the request outcome
	always_comb begin
		status_d  = ST_OK;
		total_d   = 32'd0;
		add_ok    = 1'b0;
		cancel_ok = 1'b0;
		need_scan = 1'b0;
		if (!id_ok_q) begin
			status_d = ST_UNKNOWN;
		end else if (req_q.req_type == REQ_ADD) begin
			if (slot_rd_q.live) begin
				status_d = ST_DUP;
				total_d  = cur_qty;
			end else if (sum[32] || (cur_cnt == COUNT_MAX)) begin
				status_d = ST_OVF;
				total_d  = cur_qty;
			end else begin
				add_ok  = 1'b1;
				total_d = sum[31:0];
			end
		end else begin
			if (!slot_rd_q.live) begin
				status_d = ST_UNKNOWN;
			end else begin
				cancel_ok = 1'b1;
				total_d   = diff;
				if (cnt_dec == 11'd0) begin
					need_scan = lvl_side_q ? (ask_ok_q && (ask_top_q == lvl_q)) :
						(bid_ok_q && (bid_top_q == lvl_q));
				end
			end
		end
		if (state_q != S_LEVEL) need_scan = 1'b0;
	end

	// Set a best pointer on an add only in the update step
	assign set_ask = (state_q == S_LEVEL) && add_ok && lvl_side_q &&
		(!ask_ok_q || (lvl_q < ask_top_q));
	assign set_bid = (state_q == S_LEVEL) && add_ok && !lvl_side_q &&
		(!bid_ok_q || (lvl_q > bid_top_q));

	// Outputs of the sequencer: memory writes, cell control, stall
	always_comb begin
		req_stall   = (state_q != S_IDLE);
		slot_we     = 1'b0;
		slot_wa     = slot_idx_q;
		slot_wd     = slot_rd_q;
		lvl_we      = 1'b0;
		lvl_wa      = {lvl_side_q, lvl_q};
		lvl_wd      = lvl_rd_q;
		lvl_ra      = (req_q.req_type == REQ_ADD) ? {req_q.sell_side, tick_q} :
			{slot_rd_q.side, slot_rd_q.price};
		ctl.upd     = 1'b0;
		ctl.upd_set = 1'b0;
		ctl.side    = lvl_side_q;
		ctl.bit_idx = lvl_q[2:0];
		ctl.start   = need_scan;
		ctl.scan_side = (state_q == S_LEVEL) ? lvl_side_q : scan_side_q;
		case (state_q)
			S_CLEAR: begin
				slot_we      = 1'b1;
				slot_wa      = clr_q;
				slot_wd      = '0;
			end
			S_LEVEL: begin
				if (add_ok) begin
					slot_we       = 1'b1;
					slot_wd.live  = 1'b1;
					slot_wd.side  = req_q.sell_side;
					slot_wd.price = tick_q;
					slot_wd.qty   = req_q.order_qty;
					lvl_we        = 1'b1;
					lvl_wd.qty    = sum[31:0];
					lvl_wd.cnt    = cur_cnt + 11'd1;
					ctl.upd       = 1'b1;
					ctl.upd_set   = 1'b1;
				end else if (cancel_ok) begin
					slot_we       = 1'b1;
					slot_wd.live  = 1'b0;
					lvl_we        = 1'b1;
					lvl_wd.qty    = diff;
					lvl_wd.cnt    = cnt_dec;
					ctl.upd       = (cnt_dec == 11'd0);
					ctl.upd_set   = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// Order table
	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_wa] <= slot_wd;
		if (accept) slot_rd_q <= slot_mem[slot_idx];
	end

	// Level table
	always_ff @(posedge clk) begin
		if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
		if (state_q == S_SLOT) lvl_rd_q <= lvl_mem[lvl_ra];
	end

	// Occupancy cell chain
	assign widx = lvl_q >> 3;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		assign sel_v[i] = (widx == PW'(i));
		if (i == 0) begin : g_lo
			if (NCELL > 1) begin : g_n
				assign tok_in_v[i] = scan_side_q ? 1'b0 : res[i+1].tok_out;
			end else begin : g_one
				assign tok_in_v[i] = 1'b0;
			end
		end else if (i == NCELL - 1) begin : g_hi
			assign tok_in_v[i] = scan_side_q ? res[i-1].tok_out : 1'b0;
		end else begin : g_mid
			assign tok_in_v[i] = scan_side_q ? res[i-1].tok_out : res[i+1].tok_out;
		end
		assign hit_v[i] = res[i].hit;
		assign occ_v[i] = res[i].occ;

		lobl_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.sel    (sel_v[i]),
			.tok_in (tok_in_v[i]),
			.res    (res[i])
		);
	end

	// Collect the scan outcome
	always_comb begin
		hit_word = '0;
		hit_pos  = '0;
		for (int i = 0; i < NCELL; i++) begin
			if (res[i].hit) begin
				hit_word = hit_word | CW'(i);
				hit_pos  = hit_pos | res[i].hit_pos;
			end
		end
	end

	assign hit_any = |hit_v;
	assign end_tok = scan_side_q ? res[NCELL-1].tok_out : res[0].tok_out;
	assign top_new = PW'({hit_word, hit_pos});

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			bid_ok_q    <= 1'b0;
			ask_ok_q    <= 1'b0;
			bid_top_q   <= '0;
			ask_top_q   <= '0;
			scan_side_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + SW'(1);
			if (set_ask) begin
				ask_ok_q  <= 1'b1;
				ask_top_q <= lvl_q;
			end
			if (set_bid) begin
				bid_ok_q  <= 1'b1;
				bid_top_q <= lvl_q;
			end
			if (need_scan) scan_side_q <= lvl_side_q;
			// Drop or move the best pointer once the walk ends
			if (state_q == S_SCAN) begin
				if (hit_any || end_tok) begin
					if (scan_side_q) begin
						ask_ok_q  <= hit_any;
						ask_top_q <= hit_any ? top_new : '0;
					end else begin
						bid_ok_q  <= hit_any;
						bid_top_q <= hit_any ? top_new : '0;
					end
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q      <= req;
			tick_q     <= tick_sat;
			slot_idx_q <= slot_idx;
			id_ok_q    <= (int'(req.order_id) < ORDER_SLOTS);
		end
		if (state_q == S_SLOT) begin
			lvl_side_q <= lvl_ra[LAW-1];
			lvl_q      <= lvl_ra[PW-1:0];
		end
		if (state_q == S_LEVEL) begin
			status_q <= status_d;
			total_q  <= total_d;
		end
		if (rsp_load) begin
			rsp_q.status      <= status_q;
			rsp_q.bid_valid   <= bid_ok_q;
			rsp_q.best_bid    <= bid_ok_q ? 8'(bid_top_q) : 8'd0;
			rsp_q.ask_valid   <= ask_ok_q;
			rsp_q.best_ask    <= ask_ok_q ? 8'(ask_top_q) : 8'd0;
			rsp_q.level_total <= total_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	`LOBL_ASSERT_IMP(a_one_token, state_q == S_SCAN, $onehot0(hit_v))
	`LOBL_ASSERT_NXT(a_scan_exit, state_q == S_SCAN, state_q == S_SCAN || state_q == S_DONE)
	`LOBL_ASSERT_IMP(a_bid_zero, rsp_valid && !rsp.bid_valid, rsp.best_bid == 8'd0)
	`LOBL_ASSERT_IMP(a_ask_zero, rsp_valid && !rsp.ask_valid, rsp.best_ask == 8'd0)

endmodule

`default_nettype wire

FILE: test/tb_limit_order_book_levels.sv
// ----------------------------------------------------------------------------
// tb_limit_order_book_levels
// Drives add and cancel requests into the order book level block, predicts
// status, best bid, best ask and level quantity per request, and compares
// every result in order. Runs idle and stall phases and a long hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_limit_order_book_levels;
	import lobl_pkg::*;

	localparam int SLOTS  = 1024;
	localparam int LEVELS = 256;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	limit_order_book_levels u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Book model state
	bit          live_q [SLOTS];
	bit          side_q [SLOTS];
	bit [7:0]    price_q [SLOTS];
	bit [19:0]   qty_q [SLOTS];
	bit [31:0]   lvl_qty [2][LEVELS];
	bit [10:0]   lvl_cnt [2][LEVELS];
	bit          bid_ok;
	bit [7:0]    bid_px;
	bit          ask_ok;
	bit [7:0]    ask_px;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int   errors;
	int   idle_pct;
	int   stall_pct;
	int   hold_cycles;
	bit   hold_go;
	bit   hold_done;

	// Clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
		errors++;
	endtask

	// Work out the result of one request and advance the book
	function automatic rsp_t book_apply(input req_t r);
		rsp_t      o;
		bit        s;
		bit [7:0]  p;
		int        i;
		o = '0;
		o.status = ST_OK;
		if (r.req_type == REQ_ADD) begin
			s = r.sell_side;
			p = r.price_tick;
			if (live_q[r.order_id]) begin
				o.status = ST_DUP;
				o.level_total = lvl_qty[s][p];
			end else if ({1'b0, lvl_qty[s][p]} + r.order_qty > 33'hFFFF_FFFF ||
					lvl_cnt[s][p] >= COUNT_MAX) begin
				o.status = ST_OVF;
				o.level_total = lvl_qty[s][p];
			end else begin
				live_q[r.order_id] = 1'b1;
				side_q[r.order_id] = s;
				price_q[r.order_id] = p;
				qty_q[r.order_id] = r.order_qty;
				lvl_qty[s][p] += r.order_qty;
				lvl_cnt[s][p] += 11'd1;
				o.level_total = lvl_qty[s][p];
				if (s) begin
					if (!ask_ok || p < ask_px) begin
						ask_ok = 1'b1;
						ask_px = p;
					end
				end else if (!bid_ok || p > bid_px) begin
					bid_ok = 1'b1;
					bid_px = p;
				end
			end
		end else if (!live_q[r.order_id]) begin
			o.status = ST_UNKNOWN;
		end else begin
			s = side_q[r.order_id];
			p = price_q[r.order_id];
			live_q[r.order_id] = 1'b0;
			lvl_qty[s][p] -= qty_q[r.order_id];
			if (lvl_cnt[s][p] != 0)
				lvl_cnt[s][p] -= 11'd1;
			o.level_total = lvl_qty[s][p];
			if (lvl_cnt[s][p] == 0) begin
				// rescan the side whose best level emptied
				if (s && ask_ok && ask_px == p) begin
					ask_ok = 1'b0;
					ask_px = '0;
					for (i = 0; i < LEVELS; i++)
						if (!ask_ok && lvl_cnt[1][i] != 0) begin
							ask_ok = 1'b1;
							ask_px = 8'(i);
						end
				end else if (!s && bid_ok && bid_px == p) begin
					bid_ok = 1'b0;
					bid_px = '0;
					for (i = LEVELS - 1; i >= 0; i--)
						if (!bid_ok && lvl_cnt[0][i] != 0) begin
							bid_ok = 1'b1;
							bid_px = 8'(i);
						end
				end
			end
		end
		o.bid_valid = bid_ok;
		o.best_bid = bid_ok ? bid_px : 8'd0;
		o.ask_valid = ask_ok;
		o.best_ask = ask_ok ? ask_px : 8'd0;
		return o;
	endfunction

	function automatic req_t make_req(input bit cancel, input int id, input int qty,
			input int tick, input bit sell);
		req_t r;
		r.req_type = cancel ? REQ_CANCEL : REQ_ADD;
		r.order_id = 10'(id);
		r.order_qty = 20'(qty);
		r.price_tick = 8'(tick);
		r.sell_side = sell;
		return r;
	endfunction

	// Random request: adds and cancels of likely ids near a mid price
	function automatic req_t rand_req();
		req_t r;
		r = make_req(1'($urandom_range(0, 1)), int'($urandom_range(0, 63)),
				int'($urandom_range(0, 4000)), int'($urandom_range(100, 140)),
				1'($urandom_range(0, 1)));
		case ($urandom_range(0, 9))
			0: r.order_id = 10'($urandom);
			1: r.price_tick = 8'($urandom);
			2: r.order_qty = 20'($urandom);
			default: ;
		endcase
		return r;
	endfunction

	// Driver: hold payload while stalled, predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				expected_rsps.push_back(book_apply(req));
				void'(pending_reqs.pop_front());
			end
			if ((!req_valid || !req_stall) && pending_reqs.size() > 0 &&
					!(req_valid && !req_stall && pending_reqs.size() == 0)) begin
				if (($urandom_range(0, 99) >= idle_pct)) begin
					req_valid <= 1'b1;
					req <= pending_reqs[0];
				end else begin
					req_valid <= 1'b0;
				end
			end else if (!req_valid || !req_stall) begin
				req_valid <= 1'b0;
			end
		end
	end

	// Receiver stall, with a counted hold-off when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall   <= 1'b0;
			hold_cycles <= 0;
			hold_done   <= 1'b0;
		end else if (hold_go && !hold_done) begin
			rsp_stall   <= 1'b1;
			hold_cycles <= hold_cycles + 1;
			if (hold_cycles >= 299)
				hold_done <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0) begin
				report_mismatch("unexpected result", rsp.level_total, 32'd0);
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", 32'(rsp.status), 32'(want.status));
				if (rsp.bid_valid !== want.bid_valid)
					report_mismatch("bid_valid", 32'(rsp.bid_valid), 32'(want.bid_valid));
				if (rsp.best_bid !== want.best_bid)
					report_mismatch("best_bid", 32'(rsp.best_bid), 32'(want.best_bid));
				if (rsp.ask_valid !== want.ask_valid)
					report_mismatch("ask_valid", 32'(rsp.ask_valid), 32'(want.ask_valid));
				if (rsp.best_ask !== want.best_ask)
					report_mismatch("best_ask", 32'(rsp.best_ask), 32'(want.best_ask));
				if (rsp.level_total !== want.level_total)
					report_mismatch("level_total", rsp.level_total, want.level_total);
			end
		end
	end

	// Stop a hung run
	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

	// Wait until the request queue has drained into the block
	task automatic drain();
		while (pending_reqs.size() > 0 || req_valid)
			@(posedge clk);
	endtask

	initial begin
		int ph;
		int n;
		errors = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_go = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n = 1'b1;

		// Directed: extremes, both operations and the unknown, duplicate and best-level cases
		pending_reqs.push_back(make_req(1, 5, 0, 0, 0));          // unknown cancel
		pending_reqs.push_back(make_req(0, 0, 0, 0, 0));          // zero size order
		pending_reqs.push_back(make_req(0, 1023, 20'hFFFFF, 255, 1));
		pending_reqs.push_back(make_req(0, 0, 7, 3, 1));          // duplicate id
		pending_reqs.push_back(make_req(0, 2, 10, 200, 0));
		pending_reqs.push_back(make_req(0, 3, 20, 10, 1));
		pending_reqs.push_back(make_req(0, 4, 30, 200, 0));
		pending_reqs.push_back(make_req(1, 2, 0, 0, 0));          // best keeps level
		pending_reqs.push_back(make_req(1, 4, 0, 0, 0));          // best bid empties
		pending_reqs.push_back(make_req(1, 3, 0, 0, 0));          // best ask empties
		pending_reqs.push_back(make_req(1, 1023, 0, 0, 0));
		pending_reqs.push_back(make_req(1, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(1, 1023, 0, 0, 0));
		drain();

		// Random phases with different idle and stall mixes
		for (ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 60; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 60; end
				3: begin idle_pct = 23; stall_pct = 23; end
				default: begin idle_pct = 0; stall_pct = 0; hold_go = 1'b1; end
			endcase
			for (n = 0; n < 320; n++)
				pending_reqs.push_back(rand_req());
			drain();
		end
		while (expected_rsps.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

FILE: limit_order_book_levels.f
+incdir+rtl
rtl/lobl_pkg.sv
rtl/lobl_cell.sv
rtl/limit_order_book_levels.sv
test/tb_limit_order_book_levels.sv
